/* design/pwos_pkg.sv */
// Shared types, constants and the control program for the PID smoothing unit.
// No dependencies; imported by every other module of the block.
package pwos_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SETPOINT = 2'd0,
    REG_P_GAIN   = 2'd1,
    REG_I_GAIN   = 2'd2,
    REG_D_GAIN   = 2'd3
  } reg_idx_t;

  // Input operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [15:0] p_gain;
    logic signed [15:0] i_gain;
    logic signed [15:0] d_gain;
  } cfg_t;

  // Arithmetic constants
  localparam int LIMIT_Q8      = 768000;          // +/-3000 in Q.8
  localparam int ALPHA_NEW     = 58982;           // 0.9 in Q0.16
  localparam int ALPHA_OLD_X16 = 104864;          // 0.1 in Q0.16, times 16
  localparam int RND_HALF      = 524288;          // 2^19
  localparam int DIV25_RECIP   = 335545;          // ceil(2^23 / 25)
  localparam int DIV25_SHIFT   = 23;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MS_PE,    // p_gain * error
    MS_IS,    // i_gain * error_sum
    MS_DD,    // d_gain * (error - last_error)
    MS_RLO,   // alpha_new * raw[23:0]
    MS_RHI,   // alpha_new * raw[47:24]
    MS_OLD,   // alpha_old*16 * smoothed
    MS_DIV    // reciprocal of 25 * ((|smoothed|+50) >> 2)
  } mul_sel_t;

  typedef enum logic [2:0] {
    AC_HOLD,
    AC_ZERO,
    AC_RND,   // load rounding half
    AC_ADD,   // add product
    AC_ADDH   // add product shifted up 24
  } acc_op_t;

  typedef enum logic [1:0] {
    JN_NEXT,
    JN_IFCLR,
    JN_DONE
  } jmp_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_CLR = 4'd13;

  typedef struct packed {
    mul_sel_t        mul_sel;
    acc_op_t         acc_op;
    logic            ld_err;
    logic            ld_int;
    logic            ld_raw;
    logic            ld_smooth;
    logic            clr;
    logic            emit;
    jmp_t            jmp;
    logic [PC_W-1:0] tgt;
  } ucw_t;

  typedef struct packed {
    logic en;
    ucw_t uc;
  } dp_ctrl_t;

  // Control store
  function automatic ucw_t uc_word(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{mul_sel: MS_PE, acc_op: AC_HOLD, ld_err: 1'b0, ld_int: 1'b0, ld_raw: 1'b0,
          ld_smooth: 1'b0, clr: 1'b0, emit: 1'b0, jmp: JN_NEXT, tgt: '0};
    case (pc)
      4'd0: begin
        w.ld_err = 1'b1; w.acc_op = AC_ZERO; w.jmp = JN_IFCLR; w.tgt = PC_CLR;
      end
      4'd1: begin
        w.ld_int = 1'b1; w.mul_sel = MS_PE;
      end
      4'd2: begin
        w.mul_sel = MS_IS; w.acc_op = AC_ADD;
      end
      4'd3: begin
        w.mul_sel = MS_DD; w.acc_op = AC_ADD;
      end
      4'd4: begin
        w.acc_op = AC_ADD;
      end
      4'd5: begin
        w.ld_raw = 1'b1; w.acc_op = AC_RND;
      end
      4'd6: begin
        w.mul_sel = MS_RLO;
      end
      4'd7: begin
        w.mul_sel = MS_RHI; w.acc_op = AC_ADD;
      end
      4'd8: begin
        w.mul_sel = MS_OLD; w.acc_op = AC_ADDH;
      end
      4'd9: begin
        w.acc_op = AC_ADD;
      end
      4'd10: begin
        w.ld_smooth = 1'b1;
      end
      4'd11: begin
        w.mul_sel = MS_DIV;
      end
      4'd12: begin
        w.emit = 1'b1; w.jmp = JN_DONE;
      end
      4'd13: begin
        w.clr = 1'b1; w.emit = 1'b1; w.jmp = JN_DONE;
      end
      default: begin
        w.jmp = JN_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

/* design/pid_with_output_smoothing_unit.sv */
// Top level of the positional PID unit with output smoothing.
// Depends on pwos_pkg, pwos_cfg_regs, pwos_useq and pwos_datapath.

// Positional PID step in fixed point. Each update beat carries a Q12.4
// measurement; the unit forms error = measurement - setpoint, adds it to a
// 32-bit saturating integral, builds P*e + I*sum + D*(e - last_e), blends it
// as 0.1*previous + 0.9*new (Q0.16 weights, round half up to Q.8), limits to
// +/-3000 (flag set only when strictly beyond) and returns that value / 100,
// rounded half away from zero, as Q6.8. A clear beat zeroes the integral,
// last error and smoothed drive and returns a zero result; gains and setpoint
// are kept. A microprogram of 13 steps runs on one shared 33x20 multiplier
// and a 64-bit accumulator; the last step emits the result and frees the
// unit, and the next beat is taken only after that. A clear takes 2 steps.
// The result sits in an output register, so the next input beat is accepted
// while a result is still waiting; the last step stalls only if that register
// is still occupied. Write registers only while the unit is idle.
module pid_with_output_smoothing_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] measurement
  input  logic [0:0]  in_tuser,    // [0] operation (1 = clear)
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [13:0] drive, [15:14] zero
  output logic [0:0]  out_tuser,   // [0] clamped
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pwos_pkg::*;

  cfg_t               cfg;
  dp_ctrl_t           ctrl;
  logic               busy;
  logic               in_beat;
  logic               out_block;
  logic signed [13:0] drive;
  logic               clamped;

  assign in_tready = ~busy;
  assign in_beat   = in_tvalid & in_tready;

  pwos_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pwos_useq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_beat),
    .op        (in_tuser[0]),
    .out_block (out_block),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  pwos_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .load      (in_beat),
    .meas      (signed'(in_tdata)),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .drive     (drive),
    .clamped   (clamped),
    .out_block (out_block)
  );

  assign out_tdata    = {2'b00, drive};
  assign out_tuser[0] = clamped;

endmodule

/* design/pwos_cfg_regs.sv */
// APB-style configuration registers: setpoint and the three gains.
// Depends on pwos_pkg.
module pwos_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output pwos_pkg::cfg_t      cfg
);
  import pwos_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr) begin
      case (idx)
        REG_SETPOINT: cfg_r.setpoint <= signed'(pwdata[15:0]);
        REG_P_GAIN:   cfg_r.p_gain   <= signed'(pwdata[15:0]);
        REG_I_GAIN:   cfg_r.i_gain   <= signed'(pwdata[15:0]);
        REG_D_GAIN:   cfg_r.d_gain   <= signed'(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETPOINT: prdata = 32'(cfg_r.setpoint);
      REG_P_GAIN:   prdata = 32'(cfg_r.p_gain);
      REG_I_GAIN:   prdata = 32'(cfg_r.i_gain);
      REG_D_GAIN:   prdata = 32'(cfg_r.d_gain);
      default:      prdata = '0;
    endcase
  end

endmodule

/* design/pwos_useq.sv */
// Microsequencer: step counter, control store lookup and jumps.
// Depends on pwos_pkg (control word, program).
module pwos_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,      // input beat accepted
  input  logic               op,         // operation of that beat
  input  logic               out_block,  // result register full and not taken
  output logic               busy,
  output pwos_pkg::dp_ctrl_t ctrl
);
  import pwos_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  logic            op_r, op_nxt;
  ucw_t            w;
  logic            en;

  assign w    = uc_word(pc_r);
  assign en   = busy_r & ~(w.emit & out_block);
  assign busy = busy_r;
  assign ctrl = '{en: en, uc: w};

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    op_nxt   = op_r;
    if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
      op_nxt   = op;
    end else if (en) begin
      case (w.jmp)
        JN_NEXT:  pc_nxt = pc_r + 1'b1;
        JN_IFCLR: pc_nxt = (op_r == OP_CLEAR) ? w.tgt : pc_r + 1'b1;
        JN_DONE:  busy_nxt = 1'b0;
        default:  busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
      op_r   <= OP_UPDATE;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
      op_r   <= op_nxt;
    end
  end

endmodule

/* design/pwos_datapath.sv */
// Datapath: controller state, one shared 33x20 multiplier, 64-bit accumulator,
// clamp and divide-by-100, plus the result register. Depends on pwos_pkg.
module pwos_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  pwos_pkg::cfg_t     cfg,
  input  pwos_pkg::dp_ctrl_t ctrl,
  input  logic               load,       // input beat accepted
  input  logic signed [15:0] meas,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [13:0] drive,
  output logic               clamped,
  output logic               out_block
);
  import pwos_pkg::*;

  localparam logic signed [43:0] LIM_HI = 44'(LIMIT_Q8);
  localparam logic signed [43:0] LIM_LO = -44'(LIMIT_Q8);

  // architectural state
  logic signed [31:0] sum_r, sum_nxt;
  logic signed [16:0] last_r;
  logic signed [20:0] smooth_r, smooth_nxt;
  // working registers
  logic signed [15:0] meas_r;
  logic signed [16:0] e_r;
  logic signed [17:0] dlt_r;
  logic signed [47:0] raw_r;
  logic signed [52:0] prod_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic               clamp_nxt;
  logic               clamp_w_r;  // limit flag of the item in flight
  // result register
  logic               ov_r;
  logic signed [13:0] drive_r, drive_nxt;
  logic               clamped_r;

  logic signed [32:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [32:0] s33;
  logic signed [63:0] prod_ext;
  logic signed [43:0] s44;
  logic signed [20:0] mag;
  logic        [19:0] xr;
  logic        [12:0] q;
  logic               go;

  assign go        = ctrl.en;
  assign out_block = ov_r & ~out_ready;
  assign out_valid = ov_r;
  assign drive     = drive_r;
  assign clamped   = clamped_r;

  // multiplier operands
  always_comb begin
    mag = smooth_r[20] ? -smooth_r : smooth_r;
    xr  = mag[19:0] + 20'd50;
    case (ctrl.uc.mul_sel)
      MS_PE:  begin mul_a = 33'(e_r);   mul_b = 20'(cfg.p_gain); end
      MS_IS:  begin mul_a = 33'(sum_r); mul_b = 20'(cfg.i_gain); end
      MS_DD:  begin mul_a = 33'(dlt_r); mul_b = 20'(cfg.d_gain); end
      MS_RLO: begin mul_a = signed'({9'd0, raw_r[23:0]}); mul_b = 20'(ALPHA_NEW); end
      MS_RHI: begin mul_a = 33'(signed'(raw_r[47:24]));   mul_b = 20'(ALPHA_NEW); end
      MS_OLD: begin mul_a = 33'(smooth_r); mul_b = 20'(ALPHA_OLD_X16); end
      MS_DIV: begin mul_a = signed'({15'd0, xr[19:2]}); mul_b = 20'(DIV25_RECIP); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // saturating integral
  always_comb begin
    s33 = 33'(sum_r) + 33'(e_r);
    if (s33[32] != s33[31]) begin
      sum_nxt = s33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_nxt = s33[31:0];
    end
  end

  // accumulator
  always_comb begin
    prod_ext = 64'(prod_r);
    case (ctrl.uc.acc_op)
      AC_HOLD: acc_nxt = acc_r;
      AC_ZERO: acc_nxt = '0;
      AC_RND:  acc_nxt = 64'(RND_HALF);
      AC_ADD:  acc_nxt = acc_r + prod_ext;
      AC_ADDH: acc_nxt = acc_r + (prod_ext <<< 24);
      default: acc_nxt = acc_r;
    endcase
  end

  // floor shift of the blend, then the +/-3000 limit
  always_comb begin
    s44        = acc_r[63:20];
    clamp_nxt  = 1'b0;
    smooth_nxt = s44[20:0];
    if (s44 > LIM_HI) begin
      smooth_nxt = 21'(LIMIT_Q8);
      clamp_nxt  = 1'b1;
    end else if (s44 < LIM_LO) begin
      smooth_nxt = -21'(LIMIT_Q8);
      clamp_nxt  = 1'b1;
    end
  end

  // rounded quotient by 100, sign restored
  always_comb begin
    q         = prod_r[DIV25_SHIFT+12:DIV25_SHIFT];
    drive_nxt = smooth_r[20] ? -signed'({1'b0, q}) : signed'({1'b0, q});
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      meas_r <= meas;
    end
    if (go) begin
      prod_r <= mul_a * mul_b;
      acc_r  <= acc_nxt;
      if (ctrl.uc.ld_err) begin
        e_r <= 17'(meas_r) - 17'(cfg.setpoint);
      end
      if (ctrl.uc.ld_int) begin
        dlt_r <= 18'(e_r) - 18'(last_r);
      end
      if (ctrl.uc.ld_raw) begin
        raw_r <= acc_r[47:0];
      end
      if (ctrl.uc.ld_smooth) begin
        clamp_w_r <= clamp_nxt;
      end
    end
  end

  // controller state and result register; the result register only changes
  // when a new result is emitted, so a waiting beat stays stable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      last_r    <= '0;
      smooth_r  <= '0;
      ov_r      <= 1'b0;
      clamped_r <= 1'b0;
      drive_r   <= '0;
    end else begin
      if (go && ctrl.uc.emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (go) begin
        if (ctrl.uc.clr) begin
          sum_r    <= '0;
          last_r   <= '0;
          smooth_r <= '0;
        end else begin
          if (ctrl.uc.ld_int) begin
            sum_r  <= sum_nxt;
            last_r <= e_r;
          end
          if (ctrl.uc.ld_smooth) begin
            smooth_r <= smooth_nxt;
          end
        end
        if (ctrl.uc.emit) begin
          if (ctrl.uc.clr) begin
            drive_r   <= '0;
            clamped_r <= 1'b0;
          end else begin
            drive_r   <= drive_nxt;
            clamped_r <= clamp_w_r;
          end
        end
      end
    end
  end

endmodule
